[rtl/rbbf_pkg.sv]
// package: shared types, constants and register codes for the rectangle blitter
`timescale 1ns / 1ps

package rbbf_pkg;

    localparam int MAX_DIM      = 512;
    localparam int CNT_W        = $clog2(MAX_DIM);
    localparam int DIM_W        = 10;
    localparam int ADDR_W       = 18;
    localparam int PIX_W        = 32;
    localparam int LANE_W       = 8;
    localparam int LANES        = PIX_W / LANE_W;
    localparam int MODE_W       = 2;
    localparam int SHIFT_W      = 4;
    localparam int NUM_REGS     = 8;
    localparam int REG_IDX_W    = $clog2(NUM_REGS);
    localparam int PADDR_W      = REG_IDX_W + 2;
    localparam int PDATA_W      = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LANE_W-1:0] LANE_MAX   = 8'hFF;
    localparam logic [DIM_W-1:0]  DIM_CLAMP  = DIM_W'(MAX_DIM);
    localparam int                ALPHA_LSB  = 24;

    localparam logic [MODE_W-1:0] MODE_COPY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_RECT_WIDTH  = 3'd1,
        REG_RECT_HEIGHT = 3'd2,
        REG_SRC_START   = 3'd3,
        REG_DST_START   = 3'd4,
        REG_SRC_STRIDE  = 3'd5,
        REG_DST_STRIDE  = 3'd6,
        REG_FILL_COLOR  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] src_pixel;
        logic [PIX_W-1:0] dst_pixel;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] dst_address;
        logic [ADDR_W-1:0] src_address;
        logic [PIX_W-1:0]  pixel;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [DIM_W-1:0]   rect_width;
        logic [DIM_W-1:0]   rect_height;
        logic [ADDR_W-1:0]  src_start;
        logic [ADDR_W-1:0]  dst_start;
        logic [SHIFT_W-1:0] src_stride_log2;
        logic [SHIFT_W-1:0] dst_stride_log2;
        logic [PIX_W-1:0]   fill_color;
    } t_cfg;

    // one classified pixel between front and back
    typedef struct packed {
        logic              blend;
        logic [PIX_W-1:0]  src_pixel;
        logic [PIX_W-1:0]  dst_pixel;
        logic [ADDR_W-1:0] dst_address;
        logic [ADDR_W-1:0] src_address;
        logic              last;
    } t_q_entry;

endpackage

[rtl/rbbf_regs.sv]
// configuration register file behind the apb-style port
`timescale 1ns / 1ps

module rbbf_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbbf_pkg::PADDR_W-1:0]  paddr,
    input  logic [rbbf_pkg::PDATA_W-1:0]  pwdata,
    output logic [rbbf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output rbbf_pkg::t_cfg                o_cfg
);

    rbbf_pkg::t_cfg   r_cfg;
    rbbf_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = rbbf_pkg::t_reg_idx'(paddr[rbbf_pkg::PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                rbbf_pkg::REG_MODE:        r_cfg.mode <= pwdata[rbbf_pkg::MODE_W-1:0];
                rbbf_pkg::REG_RECT_WIDTH:  r_cfg.rect_width <= pwdata[rbbf_pkg::DIM_W-1:0];
                rbbf_pkg::REG_RECT_HEIGHT: r_cfg.rect_height <= pwdata[rbbf_pkg::DIM_W-1:0];
                rbbf_pkg::REG_SRC_START:   r_cfg.src_start <= pwdata[rbbf_pkg::ADDR_W-1:0];
                rbbf_pkg::REG_DST_START:   r_cfg.dst_start <= pwdata[rbbf_pkg::ADDR_W-1:0];
                rbbf_pkg::REG_SRC_STRIDE:
                    r_cfg.src_stride_log2 <= pwdata[rbbf_pkg::SHIFT_W-1:0];
                rbbf_pkg::REG_DST_STRIDE:
                    r_cfg.dst_stride_log2 <= pwdata[rbbf_pkg::SHIFT_W-1:0];
                rbbf_pkg::REG_FILL_COLOR:  r_cfg.fill_color <= pwdata[rbbf_pkg::PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            rbbf_pkg::REG_MODE:        prdata = rbbf_pkg::PDATA_W'(r_cfg.mode);
            rbbf_pkg::REG_RECT_WIDTH:  prdata = rbbf_pkg::PDATA_W'(r_cfg.rect_width);
            rbbf_pkg::REG_RECT_HEIGHT: prdata = rbbf_pkg::PDATA_W'(r_cfg.rect_height);
            rbbf_pkg::REG_SRC_START:   prdata = rbbf_pkg::PDATA_W'(r_cfg.src_start);
            rbbf_pkg::REG_DST_START:   prdata = rbbf_pkg::PDATA_W'(r_cfg.dst_start);
            rbbf_pkg::REG_SRC_STRIDE:  prdata = rbbf_pkg::PDATA_W'(r_cfg.src_stride_log2);
            rbbf_pkg::REG_DST_STRIDE:  prdata = rbbf_pkg::PDATA_W'(r_cfg.dst_stride_log2);
            rbbf_pkg::REG_FILL_COLOR:  prdata = rbbf_pkg::PDATA_W'(r_cfg.fill_color);
            default:                   prdata = '0;
        endcase
    end

endmodule

[rtl/rbbf_front.sv]
// front end: accepts pixels, runs the raster counters, forms addresses and classifies
`timescale 1ns / 1ps

module rbbf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbbf_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    input  rbbf_pkg::t_in_item i_data,
    output logic               o_stall,
    input  logic               i_q_full,
    output logic               o_push,
    output rbbf_pkg::t_q_entry o_entry
);

    logic [rbbf_pkg::CNT_W-1:0]  r_col, n_col;
    logic [rbbf_pkg::CNT_W-1:0]  r_row, n_row;
    logic [rbbf_pkg::DIM_W-1:0]  w_w, w_h;
    logic [rbbf_pkg::DIM_W-1:0]  w_col_inc, w_row_inc;
    logic [rbbf_pkg::ADDR_W-1:0] w_src_off, w_dst_off;
    logic                        w_accept, w_empty, w_col_end, w_row_end;

    // oversized dimensions count as the maximum
    assign w_w = (i_cfg.rect_width  > rbbf_pkg::DIM_CLAMP) ? rbbf_pkg::DIM_CLAMP
                                                           : i_cfg.rect_width;
    assign w_h = (i_cfg.rect_height > rbbf_pkg::DIM_CLAMP) ? rbbf_pkg::DIM_CLAMP
                                                           : i_cfg.rect_height;
    assign w_empty = (w_w == '0) || (w_h == '0);

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    // an empty rectangle swallows the transaction without a result
    assign o_push   = w_accept && !w_empty;

    assign w_col_inc = rbbf_pkg::DIM_W'(r_col) + 1'b1;
    assign w_row_inc = rbbf_pkg::DIM_W'(r_row) + 1'b1;
    assign w_col_end = w_col_inc >= w_w;
    assign w_row_end = w_row_inc >= w_h;

    assign w_src_off = rbbf_pkg::ADDR_W'(r_row) << i_cfg.src_stride_log2;
    assign w_dst_off = rbbf_pkg::ADDR_W'(r_row) << i_cfg.dst_stride_log2;

    always_comb begin
        o_entry.blend       = (i_cfg.mode == rbbf_pkg::MODE_BLEND);
        o_entry.src_pixel   = (i_cfg.mode == rbbf_pkg::MODE_FILL) ? i_cfg.fill_color
                                                                 : i_data.src_pixel;
        o_entry.dst_pixel   = i_data.dst_pixel;
        o_entry.src_address = i_cfg.src_start + w_src_off + rbbf_pkg::ADDR_W'(r_col);
        o_entry.dst_address = i_cfg.dst_start + w_dst_off + rbbf_pkg::ADDR_W'(r_col);
        o_entry.last        = w_col_end && w_row_end;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            if (w_col_end) begin
                n_col = '0;
                n_row = w_row_end ? '0 : w_row_inc[rbbf_pkg::CNT_W-1:0];
            end else begin
                n_col = w_col_inc[rbbf_pkg::CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

[rtl/rbbf_queue.sv]
// small fifo that decouples the front end from the blend pipeline
`timescale 1ns / 1ps

module rbbf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rbbf_pkg::t_q_entry i_entry,
    input  logic               i_pop,
    output rbbf_pkg::t_q_entry o_entry,
    output logic               o_full,
    output logic               o_empty
);

    rbbf_pkg::t_q_entry          r_mem [rbbf_pkg::QUEUE_DEPTH];
    logic [rbbf_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [rbbf_pkg::QCNT_W-1:0] r_count;
    logic                        w_push, w_pop;

    assign o_full  = (r_count == rbbf_pkg::QCNT_W'(rbbf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (w_push && !w_pop)      r_count <= r_count + 1'b1;
            else if (w_pop && !w_push) r_count <= r_count - 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rbbf_pkg::QCNT_W'(rbbf_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue would drop a transaction");

    a_ptr_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == rbbf_pkg::QCNT_W'(rbbf_pkg::QUEUE_DEPTH))
            |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

[rtl/rbbf_back.sv]
// back end: premultiplied over blend or pass-through in two stages, a product stage and the output register
`timescale 1ns / 1ps

module rbbf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  rbbf_pkg::t_q_entry  i_entry,
    output logic                o_pop,
    output logic                o_valid,
    output rbbf_pkg::t_out_item o_data,
    input  logic                i_stall
);

    localparam int PROD_W = 2 * rbbf_pkg::LANE_W;

    // stage one: products inv_alpha * dst per lane
    logic                        r_s1_valid;
    logic                        r_s1_blend;
    logic [rbbf_pkg::PIX_W-1:0]  r_s1_src;
    logic [rbbf_pkg::ADDR_W-1:0] r_s1_dst_addr, r_s1_src_addr;
    logic                        r_s1_last;
    logic [PROD_W-1:0]           r_s1_prod [rbbf_pkg::LANES];

    logic                        r_out_valid;
    rbbf_pkg::t_out_item         r_out;

    logic                        w_out_free, w_s1_free;
    logic [rbbf_pkg::LANE_W-1:0] w_inv;
    logic [rbbf_pkg::PIX_W-1:0]  w_blended;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign o_pop      = !i_q_empty && w_s1_free;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    assign w_inv = rbbf_pkg::LANE_MAX -
                   i_entry.src_pixel[rbbf_pkg::ALPHA_LSB +: rbbf_pkg::LANE_W];

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_blend    <= i_entry.blend;
            r_s1_src      <= i_entry.src_pixel;
            r_s1_dst_addr <= i_entry.dst_address;
            r_s1_src_addr <= i_entry.src_address;
            r_s1_last     <= i_entry.last;
            for (int k = 0; k < rbbf_pkg::LANES; k++) begin
                r_s1_prod[k] <= PROD_W'(w_inv) *
                                PROD_W'(i_entry.dst_pixel[k*rbbf_pkg::LANE_W +: rbbf_pkg::LANE_W]);
            end
        end
    end

    // x / 255 as (x + 1 + (x >> 8)) >> 8, exact over the product range
    always_comb begin
        logic [PROD_W:0]           quo_sum;
        logic [rbbf_pkg::LANE_W:0] lane_sum;
        w_blended = '0;
        for (int k = 0; k < rbbf_pkg::LANES; k++) begin
            quo_sum  = (PROD_W+1)'(r_s1_prod[k]) + 1'b1 +
                       (PROD_W+1)'(r_s1_prod[k] >> rbbf_pkg::LANE_W);
            lane_sum = (rbbf_pkg::LANE_W+1)'(r_s1_src[k*rbbf_pkg::LANE_W +: rbbf_pkg::LANE_W]) +
                       (rbbf_pkg::LANE_W+1)'(quo_sum[PROD_W:rbbf_pkg::LANE_W]);
            w_blended[k*rbbf_pkg::LANE_W +: rbbf_pkg::LANE_W] =
                lane_sum[rbbf_pkg::LANE_W] ? rbbf_pkg::LANE_MAX
                                           : lane_sum[rbbf_pkg::LANE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_out_free) begin
            r_out.dst_address <= r_s1_dst_addr;
            r_out.src_address <= r_s1_src_addr;
            r_out.pixel       <= r_s1_blend ? w_blended : r_s1_src;
            r_out.last        <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_free)  r_s1_valid  <= o_pop;
            if (w_out_free) r_out_valid <= r_s1_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result lost or changed");

    a_stage_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_out_free) |=> r_s1_valid)
        else $error("blend stage dropped a transaction");

    a_pop_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_s1_valid || !r_out_valid || !i_stall))
        else $error("pop without room in the pipeline");
`endif

endmodule

[rtl/rect_blit_blend_fill.sv]
// top level of the rectangle blitter: registers, front end, queue and blend back end
//
// channel   direction  handshake              payload
// input     in         i_valid / o_stall      i_data  (src_pixel, dst_pixel)
// output    out        o_valid / i_stall      o_data  (dst_address, src_address, pixel, last)
// config    in         psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// one pixel per clock while i_stall is low; pixels pass queue, blend stage, output register
// the four-entry queue and the blend stage fill under an output stall, after which
// o_stall rises; the counter and address adders in the front end set the input path
// synchronous active-low reset clears registers, counters, queue and pipeline valids
// an empty rectangle accepts pixels and produces no result
`timescale 1ns / 1ps

module rect_blit_blend_fill (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  rbbf_pkg::t_in_item            i_data,
    output logic                          o_stall,
    output logic                          o_valid,
    output rbbf_pkg::t_out_item           o_data,
    input  logic                          i_stall,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbbf_pkg::PADDR_W-1:0]  paddr,
    input  logic [rbbf_pkg::PDATA_W-1:0]  pwdata,
    output logic [rbbf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    rbbf_pkg::t_cfg     w_cfg;
    rbbf_pkg::t_q_entry w_push_entry, w_pop_entry;
    logic               w_push, w_pop, w_q_full, w_q_empty;

    rbbf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rbbf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .o_stall  (o_stall),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    rbbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    rbbf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_entry   (w_pop_entry),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule
